@@ src/iee_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, codes and helper functions for the infix expression evaluator.
// No dependencies; every other file but iee_if imports this package.
package iee_pkg;

    typedef enum logic [2:0] {
        OP_ADD  = 3'd0,
        OP_SUB  = 3'd1,
        OP_MUL  = 3'd2,
        OP_DIV  = 3'd3,
        OP_POW  = 3'd4,
        OP_LPAR = 3'd5,
        OP_RPAR = 3'd6,
        OP_BAR  = 3'd7
    } t_op;

    // result status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_DIV_ZERO  = 3'd1;
    localparam logic [2:0] ST_BRACKET   = 3'd2;
    localparam logic [2:0] ST_INVALID   = 3'd3;
    localparam logic [2:0] ST_NO_RESULT = 3'd4;
    localparam logic [2:0] ST_OVERFLOW  = 3'd6;

    // character codes
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_CARET = 8'h5E;
    localparam logic [7:0] CH_LPAR  = 8'h28;
    localparam logic [7:0] CH_RPAR  = 8'h29;
    localparam logic [7:0] CH_BAR   = 8'h7C;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // controller -> datapath
    typedef struct packed {
        logic       acc_load;
        logic [3:0] digit;
        logic       flush;
        logic       op_rd;
        logic       op_push;
        t_op        push_op;
        logic       op_pop;
        logic       num_rd;
        logic       num_rd_second;
        logic       latch_a;
        logic       alu_start;
        logic       num_replace;
        logic       abs_wr;
        logic       out_load;
        logic [2:0] out_status;
        logic       clear;
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic       in_number;
        logic       n_empty;
        logic       n_lt2;
        logic       n_full;
        logic       o_empty;
        logic       o_full;
        t_op        top_op;
        logic       dig_ovf;
        logic       alu_done;
        logic [2:0] alu_status;
        logic       out_busy;
    } t_dp_status;

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic logic is_numeral(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic op_valid(input logic [7:0] c);
        logic v;
        unique case (c)
            CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH,
            CH_CARET, CH_LPAR, CH_RPAR, CH_BAR: v = 1'b1;
            default: v = 1'b0;
        endcase
        return v;
    endfunction

    function automatic t_op op_code(input logic [7:0] c);
        t_op r;
        unique case (c)
            CH_MINUS: r = OP_SUB;
            CH_STAR:  r = OP_MUL;
            CH_SLASH: r = OP_DIV;
            CH_CARET: r = OP_POW;
            CH_LPAR:  r = OP_LPAR;
            CH_RPAR:  r = OP_RPAR;
            CH_BAR:   r = OP_BAR;
            default:  r = OP_ADD;
        endcase
        return r;
    endfunction

    // does the stacked operator run before cur is pushed
    function automatic logic executes(input t_op top, input t_op cur);
        logic closing;
        logic addsub;
        logic muldiv;
        logic r;
        closing = (cur == OP_RPAR) || (cur == OP_BAR);
        addsub  = (cur == OP_ADD) || (cur == OP_SUB);
        muldiv  = (cur == OP_MUL) || (cur == OP_DIV);
        unique case (top) inside
            OP_ADD, OP_SUB: r = addsub || closing;
            OP_MUL, OP_DIV: r = addsub || muldiv || closing;
            OP_POW:         r = addsub || muldiv || (cur == OP_POW) || closing;
            OP_LPAR:        r = (cur == OP_RPAR);
            OP_BAR:         r = (cur == OP_BAR);
            default:        r = 1'b0;
        endcase
        return r;
    endfunction

    function automatic logic [31:0] magnitude(input logic [31:0] v);
        return v[31] ? (32'd0 - v) : v;
    endfunction

endpackage

@@ src/iee_if.sv @@
`timescale 1ns / 1ps
// Valid/ready channel interfaces: character beats in, result beats out.
// No dependencies.
interface iee_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       is_last;
    modport source (output valid, output char_code, output is_last, input ready);
    modport sink   (input valid, input char_code, input is_last, output ready);
endinterface

interface iee_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] value;
    logic        [2:0]  status;
    modport source (output valid, output value, output status, input ready);
    modport sink   (input valid, input value, input status, output ready);
endinterface

@@ src/iee_alu.sv @@
`timescale 1ns / 1ps
// Multi-cycle arithmetic unit: add/sub/mul in one step, radix-2 divide,
// square-and-multiply power. Depends on iee_pkg.
module iee_alu (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  iee_pkg::t_op i_op,
    input  logic [31:0]  i_a,     // right operand
    input  logic [31:0]  i_b,     // left operand
    output logic         o_done,
    output logic [31:0]  o_res,
    output logic [2:0]   o_status
);
    import iee_pkg::*;

    typedef enum logic [1:0] {A_IDLE, A_DIV, A_POW} t_alu_state;

    t_alu_state  r_state;
    logic        r_done;
    logic [31:0] r_res;
    logic [2:0]  r_status;
    logic [31:0] r_q;
    logic [31:0] r_rem;
    logic [31:0] r_dv;
    logic        r_neg;
    logic [4:0]  r_cnt;
    logic [31:0] r_base;
    logic [31:0] r_e;
    logic        r_ph;

    logic [32:0] w_t;
    logic        w_ge;
    logic [31:0] w_rem_n;
    logic [31:0] w_q_n;
    logic [31:0] w_mx;
    logic [31:0] w_my;
    logic [31:0] w_prod;

    // one restoring divide step
    assign w_t     = {r_rem, r_q[31]};
    assign w_ge    = w_t >= {1'b0, r_dv};
    assign w_rem_n = w_ge ? 32'(w_t - {1'b0, r_dv}) : w_t[31:0];
    assign w_q_n   = {r_q[30:0], w_ge};

    // single shared multiplier
    assign w_mx   = (r_state == A_IDLE) ? i_b : (r_ph ? r_base : r_res);
    assign w_my   = (r_state == A_IDLE) ? i_a : r_base;
    assign w_prod = 32'(w_mx * w_my);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= A_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                A_IDLE: begin
                    if (i_start) begin
                        r_status <= ST_OK;
                        case (i_op)
                            OP_ADD: begin
                                r_res  <= i_b + i_a;
                                r_done <= 1'b1;
                            end
                            OP_SUB: begin
                                r_res  <= i_b - i_a;
                                r_done <= 1'b1;
                            end
                            OP_MUL: begin
                                r_res  <= w_prod;
                                r_done <= 1'b1;
                            end
                            OP_DIV: begin
                                if (i_a == 32'd0) begin
                                    r_res    <= 32'd0;
                                    r_status <= ST_DIV_ZERO;
                                    r_done   <= 1'b1;
                                end else begin
                                    r_q     <= magnitude(i_b);
                                    r_rem   <= 32'd0;
                                    r_dv    <= magnitude(i_a);
                                    r_neg   <= i_a[31] ^ i_b[31];
                                    r_cnt   <= 5'd0;
                                    r_state <= A_DIV;
                                end
                            end
                            OP_POW: begin
                                r_res   <= 32'd1;
                                r_base  <= i_b;
                                r_e     <= i_a[31] ? 32'd0 : i_a;
                                r_ph    <= 1'b0;
                                r_state <= A_POW;
                            end
                            default: begin
                                // a bracket or bar reached evaluation
                                r_res    <= 32'd0;
                                r_status <= ST_BRACKET;
                                r_done   <= 1'b1;
                            end
                        endcase
                    end
                end
                A_DIV: begin
                    r_rem <= w_rem_n;
                    r_q   <= w_q_n;
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == 5'd31) begin
                        r_res   <= r_neg ? (32'd0 - w_q_n) : w_q_n;
                        r_done  <= 1'b1;
                        r_state <= A_IDLE;
                    end
                end
                A_POW: begin
                    if (r_e == 32'd0) begin
                        r_done  <= 1'b1;
                        r_state <= A_IDLE;
                    end else if (!r_ph) begin
                        if (r_e[0]) begin
                            r_res <= w_prod;
                        end
                        r_ph <= 1'b1;
                    end else begin
                        r_base <= w_prod;
                        r_e    <= {1'b0, r_e[31:1]};
                        r_ph   <= 1'b0;
                    end
                end
                default: r_state <= A_IDLE;
            endcase
        end
    end

    assign o_done   = r_done;
    assign o_res    = r_res;
    assign o_status = r_status;

endmodule

@@ src/iee_datapath.sv @@
`timescale 1ns / 1ps
// Datapath: number and operator stacks, digit accumulator, ALU, result register.
// Depends on iee_pkg, iee_if and iee_alu.
module iee_datapath #(
    parameter int STACK_DEPTH = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  iee_pkg::t_dp_cmd    i_cmd,
    output iee_pkg::t_dp_status o_status,
    iee_out_if.source           o_result
);
    import iee_pkg::*;

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int DW = $clog2(STACK_DEPTH + 1);

    logic [31:0] r_nstack [STACK_DEPTH];
    t_op         r_ostack [STACK_DEPTH];

    logic [DW-1:0] r_nd;
    logic [DW-1:0] r_od;
    logic [31:0]   r_acc;
    logic          r_in_num;
    logic [31:0]   r_nrd;
    logic [31:0]   r_opa;
    t_op           r_ord;
    logic          r_out_valid;
    logic [31:0]   r_out_value;
    logic [2:0]    r_out_status;

    logic [DW-1:0] w_nd_m1;
    logic [DW-1:0] w_nd_m2;
    logic [DW-1:0] w_od_m1;
    logic          w_n_full;
    logic          w_o_full;
    logic          w_push_num;
    logic [34:0]   w_acc10;
    logic          w_wr_en;
    logic [AW-1:0] w_wr_addr;
    logic [31:0]   w_wr_data;
    logic [AW-1:0] w_rd_addr;
    logic          w_alu_done;
    logic [31:0]   w_alu_res;
    logic [2:0]    w_alu_status;

    assign w_nd_m1    = r_nd - DW'(1);
    assign w_nd_m2    = r_nd - DW'(2);
    assign w_od_m1    = r_od - DW'(1);
    assign w_n_full   = r_nd == DW'(STACK_DEPTH);
    assign w_o_full   = r_od == DW'(STACK_DEPTH);
    assign w_push_num = i_cmd.flush && r_in_num && !w_n_full;

    // acc * 10 + digit, as shifts
    assign w_acc10 = ({3'd0, r_acc} << 3) + ({3'd0, r_acc} << 1) + 35'(i_cmd.digit);

    always_comb begin
        w_wr_en   = 1'b0;
        w_wr_addr = r_nd[AW-1:0];
        w_wr_data = r_acc;
        if (w_push_num) begin
            w_wr_en = 1'b1;
        end else if (i_cmd.num_replace) begin
            w_wr_en   = 1'b1;
            w_wr_addr = w_nd_m2[AW-1:0];
            w_wr_data = w_alu_res;
        end else if (i_cmd.abs_wr) begin
            w_wr_en   = 1'b1;
            w_wr_addr = w_nd_m1[AW-1:0];
            w_wr_data = magnitude(r_nrd);
        end
    end

    assign w_rd_addr = i_cmd.num_rd_second ? w_nd_m2[AW-1:0] : w_nd_m1[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_nstack[w_wr_addr] <= w_wr_data;
        end
        if (i_cmd.num_rd) begin
            r_nrd <= r_nstack[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op_push && !w_o_full) begin
            r_ostack[r_od[AW-1:0]] <= i_cmd.push_op;
        end
        if (i_cmd.op_rd) begin
            r_ord <= r_ostack[w_od_m1[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_a) begin
            r_opa <= r_nrd;
        end
        if (i_cmd.out_load) begin
            r_out_value  <= (i_cmd.out_status == ST_OK) ? r_nrd : 32'd0;
            r_out_status <= i_cmd.out_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nd        <= '0;
            r_od        <= '0;
            r_acc       <= 32'd0;
            r_in_num    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clear) begin
                r_nd     <= '0;
                r_od     <= '0;
                r_acc    <= 32'd0;
                r_in_num <= 1'b0;
            end else begin
                if (i_cmd.acc_load) begin
                    r_acc    <= w_acc10[31:0];
                    r_in_num <= 1'b1;
                end else if (i_cmd.flush) begin
                    r_acc    <= 32'd0;
                    r_in_num <= 1'b0;
                end
                if (w_push_num) begin
                    r_nd <= r_nd + DW'(1);
                end else if (i_cmd.num_replace) begin
                    r_nd <= w_nd_m1;
                end
                if (i_cmd.op_push && !w_o_full) begin
                    r_od <= r_od + DW'(1);
                end else if (i_cmd.op_pop) begin
                    r_od <= w_od_m1;
                end
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    iee_alu u_alu (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_cmd.alu_start),
        .i_op     (r_ord),
        .i_a      (r_opa),
        .i_b      (r_nrd),
        .o_done   (w_alu_done),
        .o_res    (w_alu_res),
        .o_status (w_alu_status)
    );

    assign o_status.in_number  = r_in_num;
    assign o_status.n_empty    = r_nd == '0;
    assign o_status.n_lt2      = r_nd < DW'(2);
    assign o_status.n_full     = w_n_full;
    assign o_status.o_empty    = r_od == '0;
    assign o_status.o_full     = w_o_full;
    assign o_status.top_op     = r_ord;
    assign o_status.dig_ovf    = w_acc10 > 35'h07FFFFFFF;
    assign o_status.alu_done   = w_alu_done;
    assign o_status.alu_status = w_alu_status;
    assign o_status.out_busy   = r_out_valid;

    assign o_result.valid  = r_out_valid;
    assign o_result.value  = $signed(r_out_value);
    assign o_result.status = r_out_status;

`ifndef NO_ASSERTIONS
    a_nd_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nd <= DW'(STACK_DEPTH))
        else $error("number stack depth out of range");
    a_replace_two: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.num_replace |-> r_nd >= DW'(2))
        else $error("operation result written with fewer than two operands");
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.op_pop |-> r_od != '0)
        else $error("pop from empty operator stack");
`endif

endmodule

@@ src/iee_ctrl.sv @@
`timescale 1ns / 1ps
// Sequencer: decodes each character beat and steps the datapath through
// flushes, operator reductions and the final evaluation. Depends on iee_pkg, iee_if.
module iee_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    iee_in_if.sink              i_char,
    input  iee_pkg::t_dp_status i_status,
    output iee_pkg::t_dp_cmd    o_cmd
);
    import iee_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_DECODE, S_OP_TEST, S_OP_EVAL, S_ABS_WR, S_NUM_A, S_NUM_B,
        S_ALU_GO, S_ALU_WAIT, S_OP_PUSH, S_LAST, S_FIN_TEST, S_OUT
    } t_state;

    t_state     r_state, n_state;
    logic [7:0] r_char, n_char;
    logic       r_last, n_last;
    logic [2:0] r_err, n_err;
    logic       r_bar, n_bar;
    logic       r_fin, n_fin;
    t_op        r_cur, n_cur;

    always_comb begin
        n_state = r_state;
        n_char  = r_char;
        n_last  = r_last;
        n_err   = r_err;
        n_bar   = r_bar;
        n_fin   = r_fin;
        n_cur   = r_cur;
        o_cmd            = '0;
        o_cmd.digit      = r_char[3:0];
        o_cmd.push_op    = r_cur;
        o_cmd.out_status = r_err;
        unique case (r_state)
            S_IDLE: begin
                if (i_char.valid) begin
                    n_char  = i_char.char_code;
                    n_last  = i_char.is_last;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                n_state = S_LAST;
                if (!is_space(r_char) && !is_numeral(r_char) && !op_valid(r_char)) begin
                    n_err = ST_INVALID;
                end else if (r_err == ST_OK && is_numeral(r_char)) begin
                    if (i_status.dig_ovf) begin
                        n_err = ST_OVERFLOW;
                    end else begin
                        o_cmd.acc_load = 1'b1;
                    end
                end else if (r_err == ST_OK && op_valid(r_char)) begin
                    n_cur       = op_code(r_char);
                    o_cmd.flush = 1'b1;
                    if (i_status.in_number && i_status.n_full) begin
                        n_err = ST_OVERFLOW;
                    end else begin
                        n_state = S_OP_TEST;
                    end
                end
            end
            S_OP_TEST: begin
                if (i_status.o_empty) begin
                    n_state = S_OP_PUSH;
                end else begin
                    o_cmd.op_rd = 1'b1;
                    n_state     = S_OP_EVAL;
                end
            end
            S_OP_EVAL: begin
                if (!executes(i_status.top_op, r_cur)) begin
                    n_state = S_OP_PUSH;
                end else if (!r_bar && r_cur == OP_BAR) begin
                    // opening bar
                    n_bar   = 1'b1;
                    n_state = S_OP_PUSH;
                end else if (i_status.top_op == OP_LPAR && r_cur == OP_RPAR) begin
                    o_cmd.op_pop = 1'b1;
                    n_state      = S_LAST;
                end else if (i_status.top_op == OP_BAR && r_cur == OP_BAR) begin
                    n_bar = 1'b0;
                    if (i_status.n_empty) begin
                        n_err   = ST_INVALID;
                        n_state = S_LAST;
                    end else begin
                        o_cmd.num_rd = 1'b1;
                        n_state      = S_ABS_WR;
                    end
                end else if (i_status.n_lt2) begin
                    n_err   = ST_INVALID;
                    n_state = S_LAST;
                end else begin
                    n_state = S_NUM_A;
                end
            end
            S_ABS_WR: begin
                o_cmd.abs_wr = 1'b1;
                o_cmd.op_pop = 1'b1;
                n_state      = S_LAST;
            end
            S_NUM_A: begin
                o_cmd.num_rd = 1'b1;
                n_state      = S_NUM_B;
            end
            S_NUM_B: begin
                o_cmd.num_rd        = 1'b1;
                o_cmd.num_rd_second = 1'b1;
                o_cmd.latch_a       = 1'b1;
                n_state             = S_ALU_GO;
            end
            S_ALU_GO: begin
                o_cmd.alu_start = 1'b1;
                n_state         = S_ALU_WAIT;
            end
            S_ALU_WAIT: begin
                if (i_status.alu_done) begin
                    if (i_status.alu_status != ST_OK) begin
                        n_err   = i_status.alu_status;
                        n_state = r_fin ? S_OUT : S_LAST;
                    end else begin
                        o_cmd.num_replace = 1'b1;
                        o_cmd.op_pop      = 1'b1;
                        n_state           = r_fin ? S_FIN_TEST : S_OP_TEST;
                    end
                end
            end
            S_OP_PUSH: begin
                if (!r_bar && r_cur == OP_BAR) begin
                    n_bar = 1'b1;
                end
                if (i_status.o_full) begin
                    n_err = ST_OVERFLOW;
                end else begin
                    o_cmd.op_push = 1'b1;
                end
                n_state = S_LAST;
            end
            S_LAST: begin
                if (!r_last) begin
                    n_state = S_IDLE;
                end else if (r_err == ST_OK) begin
                    o_cmd.flush = 1'b1;
                    if (i_status.in_number && i_status.n_full) begin
                        n_err   = ST_OVERFLOW;
                        n_state = S_OUT;
                    end else begin
                        n_fin   = 1'b1;
                        n_state = S_FIN_TEST;
                    end
                end else begin
                    n_state = S_OUT;
                end
            end
            S_FIN_TEST: begin
                if (!i_status.o_empty) begin
                    if (i_status.n_lt2) begin
                        n_err   = ST_INVALID;
                        n_state = S_OUT;
                    end else begin
                        o_cmd.op_rd = 1'b1;
                        n_state     = S_NUM_A;
                    end
                end else if (i_status.n_empty) begin
                    n_err   = ST_NO_RESULT;
                    n_state = S_OUT;
                end else begin
                    o_cmd.num_rd = 1'b1;
                    n_state      = S_OUT;
                end
            end
            S_OUT: begin
                if (!i_status.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.clear    = 1'b1;
                    n_err          = ST_OK;
                    n_bar          = 1'b0;
                    n_fin          = 1'b0;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_err   <= ST_OK;
            r_bar   <= 1'b0;
            r_fin   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_err   <= n_err;
            r_bar   <= n_bar;
            r_fin   <= n_fin;
        end
        r_char <= n_char;
        r_last <= n_last;
        r_cur  <= n_cur;
    end

    assign i_char.ready = (r_state == S_IDLE);

endmodule

@@ src/infix_expression_evaluator_top.sv @@
`timescale 1ns / 1ps
// Sequence: whitespace and digit beats are decoded and done; an operator beat flushes any
// pending number, then runs its reductions, each fetching two operands and waiting on the ALU.
// The last beat adds the final reductions; its result is then registered for output.
// Throughput: one beat at a time, set by the shared iterative ALU in the reduce loop.
// Reset: synchronous active-low, clears depths, accumulator and error; no clearing pass.
// Depends on iee_pkg, iee_if, iee_ctrl, iee_datapath (and iee_alu below it).
module infix_expression_evaluator_top #(
    parameter int STACK_DEPTH = 64
) (
    input logic       i_clk,
    input logic       i_rst_n,
    iee_in_if.sink    i_char_ch,    // character beats
    iee_out_if.source o_result_ch   // one result beat per last character
);
    import iee_pkg::*;

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    // Controller: decode, stack reductions, end-of-expression evaluation.
    iee_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_char   (i_char_ch),
        .i_status (w_status),
        .o_cmd    (w_cmd)
    );

    // Datapath: stacks are memories with a write port and a registered read port,
    // so each operand fetch goes through a read register; the result register decouples
    // the output channel from the sequencer.
    iee_datapath #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .o_status (w_status),
        .o_result (o_result_ch)
    );

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking bench for the infix expression evaluator: random and directed
// expressions in, results checked against an in-bench two-stack predictor.
// Depends on iee_pkg, iee_if and infix_expression_evaluator_top.
module tb_top;
    import iee_pkg::*;

    localparam int DEPTH = 64;

    // expected results, oldest first, with the evaluator state that predicts them
    class expr_scoreboard;
        logic [31:0] nums[DEPTH];
        t_op         ops[DEPTH];
        int          n_cnt;
        int          o_cnt;
        bit          bar_on;
        logic [31:0] acc;
        bit          in_num;
        logic [2:0]  err;
        logic [31:0] exp_value[$];
        logic [2:0]  exp_status[$];
        int          fails;

        function void clear_state();
            n_cnt = 0; o_cnt = 0; bar_on = 0; acc = 0; in_num = 0; err = ST_OK;
        endfunction

        function logic [2:0] apply(t_op op, logic [31:0] a, logic [31:0] b,
                                   output logic [31:0] r);
            logic [31:0] q;
            logic [31:0] base;
            logic [31:0] e;
            r = 0;
            case (op)
                OP_ADD: r = b + a;
                OP_SUB: r = b - a;
                OP_MUL: r = b * a;
                OP_DIV: begin
                    if (a == 0) return ST_DIV_ZERO;
                    q = magnitude(b) / magnitude(a);
                    r = (a[31] ^ b[31]) ? 32'd0 - q : q;
                end
                OP_POW: begin
                    r = 1; base = b; e = a[31] ? 32'd0 : a;
                    while (e != 0) begin
                        if (e[0]) r = r * base;
                        base = base * base;
                        e = e >> 1;
                    end
                end
                default: return ST_BRACKET;
            endcase
            return ST_OK;
        endfunction

        function void push_num(logic [31:0] v);
            if (n_cnt >= DEPTH) err = ST_OVERFLOW;
            else begin
                nums[n_cnt] = v; n_cnt++;
            end
        endfunction

        function void flush();
            if (in_num) begin
                in_num = 0; push_num(acc); acc = 0;
            end
        endfunction

        function void do_op(t_op cur);
            bit matched;
            t_op top;
            logic [31:0] r;
            matched = 0;
            while (o_cnt > 0 && executes(ops[o_cnt-1], cur)) begin
                top = ops[o_cnt-1];
                if (!bar_on && cur == OP_BAR) begin
                    bar_on = 1; break;
                end
                if (top == OP_LPAR && cur == OP_RPAR) begin
                    o_cnt--; matched = 1; break;
                end
                if (top == OP_BAR && cur == OP_BAR) begin
                    matched = 1; bar_on = 0;
                    if (n_cnt == 0) begin
                        err = ST_INVALID; return;
                    end
                    nums[n_cnt-1] = magnitude(nums[n_cnt-1]);
                    o_cnt--; break;
                end
                if (n_cnt < 2) begin
                    err = ST_INVALID; return;
                end
                err = apply(top, nums[n_cnt-1], nums[n_cnt-2], r);
                n_cnt -= 2;
                if (err != ST_OK) return;
                nums[n_cnt] = r; n_cnt++; o_cnt--;
            end
            if (!matched) begin
                if (cur == OP_BAR && !bar_on) bar_on = 1;
                if (o_cnt >= DEPTH) begin
                    err = ST_OVERFLOW; return;
                end
                ops[o_cnt] = cur; o_cnt++;
            end
        endfunction

        function logic [31:0] reduce_all();
            logic [31:0] r;
            while (o_cnt > 0) begin
                if (n_cnt < 2) begin
                    err = ST_INVALID; return 0;
                end
                err = apply(ops[o_cnt-1], nums[n_cnt-1], nums[n_cnt-2], r);
                n_cnt -= 2;
                if (err != ST_OK) return 0;
                nums[n_cnt] = r; n_cnt++; o_cnt--;
            end
            if (n_cnt == 0) begin
                err = ST_NO_RESULT; return 0;
            end
            return nums[n_cnt-1];
        endfunction

        // one accepted character beat
        function void note_char(logic [7:0] c, logic last);
            logic [31:0] v;
            logic [31:0] d;
            if (!is_space(c) && !is_numeral(c) && !op_valid(c)) err = ST_INVALID;
            else if (err == ST_OK && is_numeral(c)) begin
                d = 32'(c - CH_ZERO);
                if (acc > (32'd2147483647 - d) / 10) err = ST_OVERFLOW;
                else begin
                    acc = acc * 10 + d; in_num = 1;
                end
            end else if (err == ST_OK && op_valid(c)) begin
                flush();
                if (err == ST_OK) do_op(op_code(c));
            end
            if (last) begin
                v = 0;
                if (err == ST_OK) flush();
                if (err == ST_OK) v = reduce_all();
                if (err != ST_OK) v = 0;
                exp_value.push_back(v);
                exp_status.push_back(err);
                clear_state();
            end
        endfunction

        function void check_result(logic [31:0] value, logic [2:0] status);
            if (exp_value.size() == 0) begin
                $error("unexpected result beat value=%0d status=%0d", $signed(value), status);
                fails++;
                return;
            end
            if (value !== exp_value[0]) begin
                $error("value: expected %0d, actual %0d", $signed(exp_value[0]),
                       $signed(value));
                fails++;
            end
            if (status !== exp_status[0]) begin
                $error("status: expected %0d, actual %0d", exp_status[0], status);
                fails++;
            end
            void'(exp_value.pop_front());
            void'(exp_status.pop_front());
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    iee_in_if  char_ch ();
    iee_out_if result_ch ();

    infix_expression_evaluator_top #(.STACK_DEPTH(DEPTH)) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_char_ch  (char_ch.sink),
        .o_result_ch(result_ch.source)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    expr_scoreboard sb = new();
    bit   send_done = 0;
    bit   hold_rx = 0;       // long receiver hold-off while the sender keeps pushing
    bit   quiet_phase = 0;   // stretch with no idling on either side
    int   exprs_sent = 0;
    byte  expr_buf[$];

    initial begin
        char_ch.valid = 1'b0;
        char_ch.char_code = 8'd0;
        char_ch.is_last = 1'b0;
        result_ch.ready = 1'b0;
    end

    // sends one character beat: random gap, then hold valid until accepted
    task automatic send_char(logic [7:0] c, logic last);
        int gap;
        gap = quiet_phase ? 0 : $urandom_range(0, 18);
        if (gap > 0 && char_ch.valid) begin
            char_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end else if (gap > 0) begin
            repeat (gap) @(negedge i_clk);
        end
        char_ch.valid <= 1'b1;
        char_ch.char_code <= c;
        char_ch.is_last <= last;
        @(posedge i_clk);
        while (!char_ch.ready) @(posedge i_clk);
        sb.note_char(c, last);
        @(negedge i_clk);
    endtask

    task automatic send_expr();
        for (int k = 0; k < expr_buf.size(); k++)
            send_char(expr_buf[k], k == expr_buf.size() - 1);
        exprs_sent++;
        expr_buf.delete();
    endtask

    task automatic put_str(string s);
        for (int k = 0; k < s.len(); k++) expr_buf.push_back(s[k]);
    endtask

    function automatic byte rand_op();
        byte tbl[8] = '{CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_CARET,
                        CH_LPAR, CH_RPAR, CH_BAR};
        return tbl[$urandom_range(0, 7)];
    endfunction

    // well-formed-ish expression: operands, binary ops, nested brackets and bars
    task automatic build_operand(int lvl);
        int pick;
        pick = (lvl > 2) ? 0 : $urandom_range(0, 5);
        if (pick == 4) begin
            expr_buf.push_back(CH_LPAR); build_expr(lvl + 1); expr_buf.push_back(CH_RPAR);
        end else if (pick == 5) begin
            expr_buf.push_back(CH_BAR); build_expr(lvl + 1); expr_buf.push_back(CH_BAR);
        end else begin
            int nd;
            nd = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 11) : $urandom_range(1, 3);
            for (int k = 0; k < nd; k++) begin
                expr_buf.push_back(byte'(CH_ZERO + $urandom_range(0, 9)));
                if ($urandom_range(0, 15) == 0) expr_buf.push_back(CH_SPACE);
            end
        end
    endtask

    task automatic build_expr(int lvl);
        int terms;
        byte ops5[5] = '{CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_CARET};
        terms = $urandom_range(1, 4);
        build_operand(lvl);
        for (int k = 1; k < terms; k++) begin
            if ($urandom_range(0, 3) == 0) expr_buf.push_back(8'(CH_TAB + $urandom_range(0, 4)));
            expr_buf.push_back(ops5[$urandom_range(0, 4)]);
            build_operand(lvl);
        end
    endtask

    // stimulus
    initial begin
        string directed[$];
        directed = '{"1+2*3", "2147483647", "2147483648", "(1+2)*3", "|3-10|",
                     "7/-2", "7/0", "2^-1", "2^10^2", "3^31", "(1+2", "1+", "",
                     "  ", "1 2 3+4", "5a", "9/3-1)", "||", "0-2147483647-1",
                     "(0-2147483647-1)/(0-1)", "|0-5|*|2-9|+8/3"};
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        foreach (directed[k]) begin
            put_str(directed[k]);
            if (expr_buf.size() == 0) expr_buf.push_back(CH_SPACE);
            send_expr();
        end
        // every character code, last on an illegal character
        for (int c = 0; c < 256; c++) expr_buf.push_back(byte'(c));
        send_expr();
        put_str("1+1"); expr_buf.push_back(8'hFF); send_expr();
        // deep nesting to overflow the operator stack
        repeat (DEPTH + 2) expr_buf.push_back(CH_LPAR);
        put_str("1"); send_expr();
        // many numbers to overflow the number stack
        repeat (DEPTH + 2) put_str("1(");
        put_str("1"); send_expr();

        // receiver hold-off: keep feeding until the input stalls
        hold_rx = 1;
        quiet_phase = 1;
        repeat (8) begin
            build_expr(0); send_expr();
        end
        quiet_phase = 0;
        hold_rx = 0;

        while (exprs_sent < 58) begin
            int kind;
            kind = $urandom_range(0, 9);
            if (kind < 7) build_expr(0);
            else if (kind < 9) begin
                build_expr(0);
                repeat ($urandom_range(1, 3))
                    expr_buf.insert($urandom_range(0, expr_buf.size()), rand_op());
            end else begin
                repeat ($urandom_range(1, 8))
                    expr_buf.push_back(($urandom_range(0, 1) ? rand_op()
                                        : byte'($urandom_range(0, 255))));
            end
            quiet_phase = ($urandom_range(0, 9) == 0);
            send_expr();
        end
        char_ch.valid <= 1'b0;
        send_done = 1;
    end

    // result side: random stalls plus long hold-offs while hold_rx is set
    initial begin
        int stall;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_rx) begin
                result_ch.ready <= 1'b0;
                repeat (400) @(negedge i_clk);
            end
            stall = quiet_phase ? 0 : $urandom_range(0, 18);
            if (stall > 0) begin
                result_ch.ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            result_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (!result_ch.valid) @(posedge i_clk);
            sb.check_result(result_ch.value, result_ch.status);
        end
    end

    // end of run
    initial begin
        wait (send_done);
        while (sb.exp_value.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (sb.fails == 0) $display("SUCCESS");
        else $display("FAILURE");
        $finish;
    end

    initial begin
        #60ms;
        $display("FAILURE");
        $finish;
    end
endmodule
